// ===== hw/rtl/pipc_pkg.sv =====
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared constants and types for the point-in-convex-polygon test.
// ----------------------------------------------------------------------------
package pipc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 4;
  localparam int PT_WIDTH        = 12;
  localparam int AXES            = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Control flags that travel with a vertex through the edge stage.
  typedef struct packed {
    logic edge_en;   // a previous vertex exists, so the open edge is tested
    logic last;      // closing vertex of the polygon
    logic two_plus;  // polygon holds at least two vertices
  } stage_flags_t;

endpackage

// ===== hw/rtl/pipc_vertex_if.sv =====
// ----------------------------------------------------------------------------
// pipc_vertex_if
// Vertex channel: one polygon vertex and the query point per beat.
// ----------------------------------------------------------------------------
interface pipc_vertex_if #(
  parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_WIDTH-1:0]        vertex_x;
  logic signed [COORD_WIDTH-1:0]        vertex_y;
  logic signed [COORD_WIDTH-1:0]        vertex_z;
  logic signed [pipc_pkg::PT_WIDTH-1:0] point_x;
  logic signed [pipc_pkg::PT_WIDTH-1:0] point_y;
  logic signed [pipc_pkg::PT_WIDTH-1:0] point_z;
  logic                                 last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, point_x, point_y, point_z,
                  last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, point_x, point_y, point_z,
                last_vertex, output ready);
endinterface

// ===== hw/rtl/pipc_result_if.sv =====
// ----------------------------------------------------------------------------
// pipc_result_if
// Result channel: one inside flag per beat.
// ----------------------------------------------------------------------------
interface pipc_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== hw/rtl/pipc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pipc_cfg_if
// Configuration write channel carrying the check_xz register value.
// ----------------------------------------------------------------------------
interface pipc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/pipc_cross_sign.sv =====
// ----------------------------------------------------------------------------
// pipc_cross_sign
// Sign of the exact cross product as*bt - at*bs of two offset vectors.
// ----------------------------------------------------------------------------
module pipc_cross_sign #(
  parameter int OFS_W = 17
) (
  input  logic signed [OFS_W-1:0] a_s,
  input  logic signed [OFS_W-1:0] a_t,
  input  logic signed [OFS_W-1:0] b_s,
  input  logic signed [OFS_W-1:0] b_t,
  output logic                    neg
);
  localparam int PROD_W = 2 * OFS_W;

  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W:0]   diff;

  assign prod_p = a_s * b_t;
  assign prod_q = a_t * b_s;
  assign diff   = (PROD_W + 1)'(prod_p) - (PROD_W + 1)'(prod_q);
  assign neg    = diff[PROD_W];
endmodule

// ===== hw/rtl/pipc_edge.sv =====
// ----------------------------------------------------------------------------
// pipc_edge
// Tests one edge against the query point in the xy and, optionally, the xz
// projection.
// ----------------------------------------------------------------------------
module pipc_edge #(
  parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pipc_pkg::FRAC_BITS_DEF
) (
  input  logic [COORD_WIDTH-1:0]        start_v [pipc_pkg::AXES],
  input  logic [COORD_WIDTH-1:0]        end_v   [pipc_pkg::AXES],
  input  logic [pipc_pkg::PT_WIDTH-1:0] query   [pipc_pkg::AXES],
  input  logic                          check_xz,
  output logic                          neg
);
  import pipc_pkg::*;

  localparam int PT_SHIFT_W = PT_WIDTH + FRAC_BITS;
  localparam int OFS_W = ((COORD_WIDTH > PT_SHIFT_W) ? COORD_WIDTH : PT_SHIFT_W) + 1;

  logic signed [OFS_W-1:0] pt_scaled [AXES];
  logic signed [OFS_W-1:0] ofs_a     [AXES];
  logic signed [OFS_W-1:0] ofs_b     [AXES];
  logic                    neg_xy;
  logic                    neg_xz;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pt_scaled[i] = OFS_W'($signed(query[i])) <<< FRAC_BITS;
      ofs_a[i]     = OFS_W'($signed(start_v[i])) - pt_scaled[i];
      ofs_b[i]     = OFS_W'($signed(end_v[i])) - pt_scaled[i];
    end
  end

  pipc_cross_sign #(.OFS_W(OFS_W)) u_xy (
    .a_s (ofs_a[AXIS_X]),
    .a_t (ofs_a[AXIS_Y]),
    .b_s (ofs_b[AXIS_X]),
    .b_t (ofs_b[AXIS_Y]),
    .neg (neg_xy)
  );

  pipc_cross_sign #(.OFS_W(OFS_W)) u_xz (
    .a_s (ofs_a[AXIS_X]),
    .a_t (ofs_a[AXIS_Z]),
    .b_s (ofs_b[AXIS_X]),
    .b_t (ofs_b[AXIS_Z]),
    .neg (neg_xz)
  );

  assign neg = neg_xy | (check_xz & neg_xz);
endmodule

// ===== hw/rtl/pipc_capture.sv =====
// ----------------------------------------------------------------------------
// pipc_capture
// Keeps the first vertex, previous vertex and query point of the current
// polygon, and registers each accepted vertex with its edge operands.
// ----------------------------------------------------------------------------
module pipc_capture #(
  parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          advance,
  input  logic [COORD_WIDTH-1:0]        in_v     [pipc_pkg::AXES],
  input  logic [pipc_pkg::PT_WIDTH-1:0] in_p     [pipc_pkg::AXES],
  input  logic                          in_last,
  output logic                          st_valid,
  output pipc_pkg::stage_flags_t        st_flags,
  output logic [pipc_pkg::PT_WIDTH-1:0] st_query [pipc_pkg::AXES],
  output logic [COORD_WIDTH-1:0]        st_start [pipc_pkg::AXES],
  output logic [COORD_WIDTH-1:0]        st_end   [pipc_pkg::AXES],
  output logic [COORD_WIDTH-1:0]        st_first [pipc_pkg::AXES]
);
  import pipc_pkg::*;

  logic                   started;
  logic [PT_WIDTH-1:0]    query   [AXES];
  logic [COORD_WIDTH-1:0] first_v [AXES];
  logic [COORD_WIDTH-1:0] prev_v  [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      st_valid <= 1'b0;
    end else if (accept) begin
      started  <= ~in_last;
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < AXES; i++) begin
        if (!started) begin
          query[i]    <= in_p[i];
          first_v[i]  <= in_v[i];
          st_query[i] <= in_p[i];
          st_first[i] <= in_v[i];
        end else begin
          st_query[i] <= query[i];
          st_first[i] <= first_v[i];
        end
        prev_v[i]   <= in_v[i];
        st_start[i] <= prev_v[i];
        st_end[i]   <= in_v[i];
      end
      st_flags.edge_en  <= started;
      st_flags.last     <= in_last;
      st_flags.two_plus <= started;
    end
  end
endmodule

// ===== hw/rtl/point_in_convex_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_convex_polygon_test
// Streams polygon vertices and reports whether the query point lies inside
// or on the convex polygon.
// Latency: the last vertex of a polygon passes the capture register and the edge
// stage, and its result is then held in the output register. Throughput: one
// vertex per cycle, set by the single edge stage that tests the open and closing
// edges side by side, unless a closing vertex waits on a result not yet taken. Reset clears the polygon
// progress, the accumulated flag, check_xz and all valid state; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_test #(
  parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pipc_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  pipc_vertex_if.sink  vertex,
  pipc_result_if.source result,
  pipc_cfg_if.sink     cfg
);
  import pipc_pkg::*;

  logic                   check_xz;
  logic                   in_accept;
  logic                   advance;
  logic                   st_valid;
  stage_flags_t           st_flags;
  logic [PT_WIDTH-1:0]    st_query [AXES];
  logic [COORD_WIDTH-1:0] st_start [AXES];
  logic [COORD_WIDTH-1:0] st_end   [AXES];
  logic [COORD_WIDTH-1:0] st_first [AXES];
  logic [COORD_WIDTH-1:0] in_v     [AXES];
  logic [PT_WIDTH-1:0]    in_p     [AXES];
  logic                   open_neg;
  logic                   close_neg;
  logic                   all_nonneg;
  logic                   nonneg_next;
  logic                   out_valid;
  logic                   out_inside;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_xz <= 1'b0;
    end else if (cfg.valid) begin
      check_xz <= cfg.data;
    end
  end

  assign in_v[AXIS_X] = vertex.vertex_x;
  assign in_v[AXIS_Y] = vertex.vertex_y;
  assign in_v[AXIS_Z] = vertex.vertex_z;
  assign in_p[AXIS_X] = vertex.point_x;
  assign in_p[AXIS_Y] = vertex.point_y;
  assign in_p[AXIS_Z] = vertex.point_z;

  assign advance      = st_valid & (~st_flags.last | ~out_valid | result.ready);
  assign vertex.ready = ~st_valid | advance;
  assign in_accept    = vertex.valid & vertex.ready;

  pipc_capture #(.COORD_WIDTH(COORD_WIDTH)) u_capture (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .advance  (advance),
    .in_v     (in_v),
    .in_p     (in_p),
    .in_last  (vertex.last_vertex),
    .st_valid (st_valid),
    .st_flags (st_flags),
    .st_query (st_query),
    .st_start (st_start),
    .st_end   (st_end),
    .st_first (st_first)
  );

  pipc_edge #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_open_edge (
    .start_v  (st_start),
    .end_v    (st_end),
    .query    (st_query),
    .check_xz (check_xz),
    .neg      (open_neg)
  );

  pipc_edge #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_close_edge (
    .start_v  (st_end),
    .end_v    (st_first),
    .query    (st_query),
    .check_xz (check_xz),
    .neg      (close_neg)
  );

  assign nonneg_next = st_flags.edge_en ? (all_nonneg & ~open_neg) : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      all_nonneg <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        all_nonneg <= st_flags.last ? 1'b1 : nonneg_next;
      end
      if (advance && st_flags.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st_flags.last) begin
      out_inside <= nonneg_next & ~close_neg & (check_xz | st_flags.two_plus);
    end
  end

  assign result.valid      = out_valid;
  assign result.inside_res = out_inside;
endmodule

// ===== hw/rtl/pipc_checker.sv =====
// ----------------------------------------------------------------------------
// pipc_checker
// Port-level checks on the point-in-convex-polygon test, bound to the top.
// ----------------------------------------------------------------------------
module pipc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic inside_res
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(inside_res))
    else $error("Result beat changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result beat present after reset.");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("Vertex channel not ready after reset.");
endmodule

bind point_in_convex_polygon_test pipc_checker u_pipc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (vertex.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .inside_res (result.inside_res)
);

// ===== verif/point_in_convex_polygon_test_tb.sv =====
// ----------------------------------------------------------------------------
// point_in_convex_polygon_test_tb
// Streams polygons into the point-in-polygon block and checks every inside
// flag. A short directed table covers the coordinate extremes, one- and
// two-vertex polygons, both winding orders and changes of check_xz, including
// one made part-way through a polygon. Random convex shapes and random noise
// then follow under four settings of register value and handshake pressure.
// Each flag is held to its table value or one worked out from the vertices.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW  = pipc_pkg::COORD_WIDTH_DEF;
  localparam int FB  = pipc_pkg::FRAC_BITS_DEF;
  localparam int PTW = pipc_pkg::PT_WIDTH;

  localparam int  IDLE_MAX       = 14;
  localparam int  DRAIN_CYCLES   = 6;
  localparam int  DRAIN_LIMIT    = 4000;
  localparam int  PHASE_VERTICES = 230;
  localparam logic MODE_XY       = 1'b0;
  localparam logic MODE_XZ       = 1'b1;

  localparam int DIR_A [8] = '{10, 7, 0, -7, -10, -7, 0, 7};
  localparam int DIR_B [8] = '{0, 7, 10, 7, 0, -7, -10, -7};

  typedef struct packed {
    logic signed [CW-1:0]  vx;
    logic signed [CW-1:0]  vy;
    logic signed [CW-1:0]  vz;
    logic signed [PTW-1:0] px;
    logic signed [PTW-1:0] py;
    logic signed [PTW-1:0] pz;
    logic                  last;
  } vertex_beat_t;

  typedef enum logic [1:0] {
    CFG_KEEP,
    CFG_SET_XY,
    CFG_SET_XZ
  } cfg_step_t;

  typedef struct packed {
    vertex_beat_t beat;
    cfg_step_t    cfg_op;
    logic         typed;
    logic         typed_inside;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [23] = '{
    '{'{0, 0, 0, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b1, 1'b0},
    '{'{-16, -16, 0, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, -16, 0, 2047, -2048, 2047, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, 16, 0, -1, -1, -1, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{-16, 16, 0, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b1, 1'b1},
    '{'{-16, -16, 0, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{-16, 16, 0, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, 16, 0, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, -16, 0, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b1, 1'b0},
    '{'{-32768, -32768, -32768, -2048, -2048, -2048, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{32767, -32768, 32767, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{0, 32767, 0, 2047, 2047, 2047, 1'b1}, CFG_KEEP, 1'b0, 1'b0},
    '{'{32767, 32767, 32767, 2047, 2047, 2047, 1'b1}, CFG_SET_XZ, 1'b1, 1'b1},
    '{'{-16, -16, 16, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, -16, 16, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, 16, -16, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{-16, 16, -16, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b0, 1'b0},
    '{'{-16, -16, 0, 0, 0, 0, 1'b0}, CFG_KEEP, 1'b0, 1'b0},
    '{'{16, -16, 0, 0, 0, 0, 1'b0}, CFG_SET_XY, 1'b0, 1'b0},
    '{'{16, 16, 5, 0, 0, 0, 1'b0}, CFG_SET_XZ, 1'b0, 1'b0},
    '{'{-16, 16, -5, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b0, 1'b0},
    '{'{-32, 0, 0, 0, 0, 0, 1'b0}, CFG_SET_XY, 1'b0, 1'b0},
    '{'{32, 0, 0, 0, 0, 0, 1'b1}, CFG_KEEP, 1'b1, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pipc_vertex_if #(.COORD_WIDTH(CW)) vertex_ch ();
  pipc_result_if                     result_ch ();
  pipc_cfg_if                        cfg_ch ();

  point_in_convex_polygon_test #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (FB)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .vertex(vertex_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the polygon progress kept by the block.
  vertex_beat_t          first_vtx;
  vertex_beat_t          prev_vtx;
  logic signed [PTW-1:0] query_px;
  logic signed [PTW-1:0] query_py;
  logic signed [PTW-1:0] query_pz;
  logic                  hull_ok = 1'b1;
  int                    verts_seen = 0;
  logic                  check_xz_q = MODE_XY;

  logic expected_inside [$];

  int sender_max_gap     = 3;
  int receiver_max_stall = IDLE_MAX;
  int fail_count         = 0;
  int vertices_sent      = 0;
  int results_seen       = 0;
  int inside_count       = 0;
  int cfg_writes         = 0;

  function automatic longint axis_offset(input logic signed [CW-1:0] v,
                                         input logic signed [PTW-1:0] p);
    return longint'(v) - longint'(p) * (longint'(1) << FB);
  endfunction

  function automatic logic cross_negative(input longint sa, input longint ta,
                                          input longint sb, input longint tb);
    return (sa * tb - ta * sb) < 0;
  endfunction

  function automatic logic edge_fails(input vertex_beat_t s, input vertex_beat_t e);
    longint ax, ay, az, bx, by, bz;
    ax = axis_offset(s.vx, query_px);
    ay = axis_offset(s.vy, query_py);
    az = axis_offset(s.vz, query_pz);
    bx = axis_offset(e.vx, query_px);
    by = axis_offset(e.vy, query_py);
    bz = axis_offset(e.vz, query_pz);
    if (cross_negative(ax, ay, bx, by)) return 1'b1;
    return check_xz_q && cross_negative(ax, az, bx, bz);
  endfunction

  function automatic void polygon_step(input vertex_beat_t b, output logic done,
                                       output logic is_in);
    done = 1'b0;
    is_in = 1'b0;
    if (verts_seen == 0) begin
      query_px = b.px;
      query_py = b.py;
      query_pz = b.pz;
      first_vtx = b;
      hull_ok = 1'b1;
    end else if (edge_fails(prev_vtx, b)) begin
      hull_ok = 1'b0;
    end
    prev_vtx = b;
    if (verts_seen < 2) verts_seen++;
    if (b.last) begin
      if (edge_fails(b, first_vtx)) hull_ok = 1'b0;
      done = 1'b1;
      is_in = hull_ok && (check_xz_q || verts_seen >= 2);
      verts_seen = 0;
      hull_ok = 1'b1;
    end
  endfunction

  task automatic send_vertex(input vertex_beat_t b, input logic typed,
                             input logic typed_inside);
    int   gap;
    logic done;
    logic is_in;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      vertex_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_ch.valid       <= 1'b1;
    vertex_ch.vertex_x    <= b.vx;
    vertex_ch.vertex_y    <= b.vy;
    vertex_ch.vertex_z    <= b.vz;
    vertex_ch.point_x     <= b.px;
    vertex_ch.point_y     <= b.py;
    vertex_ch.point_z     <= b.pz;
    vertex_ch.last_vertex <= b.last;
    do @(posedge clk); while (!vertex_ch.ready);
    polygon_step(b, done, is_in);
    vertices_sent++;
    if (done) expected_inside = {expected_inside, (typed ? typed_inside : is_in)};
  endtask

  // The register is only written once every flag has come back and the
  // pipeline has had time to empty.
  task automatic write_check_xz(input logic value);
    vertex_ch.valid <= 1'b0;
    while (expected_inside.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    check_xz_q = value;
    cfg_writes++;
  endtask

  // Mostly convex shapes on an octagon around a random centre, wound either
  // way, with the point placed near them; the rest are polygons of random
  // vertices.
  task automatic send_random_polygon();
    logic         shaped;
    logic         first;
    int           zstyle;
    int           cx, cy, cz, qx, qy, qz;
    int           radius, reach, first_dir, dir_step, n_left, idx;
    logic [7:0]   pick;
    vertex_beat_t b;
    shaped = ($urandom_range(0, 3) != 0);
    zstyle = $urandom_range(0, 2);
    cx = int'($urandom_range(0, 3000)) - 1500;
    cy = int'($urandom_range(0, 3000)) - 1500;
    cz = int'($urandom_range(0, 3000)) - 1500;
    radius = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 8000);
    reach = radius / 16 + 2;
    qx = cx + int'($urandom_range(0, 2 * reach)) - reach;
    qy = cy + int'($urandom_range(0, 2 * reach)) - reach;
    qz = cz + int'($urandom_range(0, 2 * reach)) - reach;
    if (shaped) pick = 8'($urandom_range(1, 255));
    else pick = 8'((1 << $urandom_range(1, 6)) - 1);
    first_dir = $urandom_range(0, 7);
    dir_step = ($urandom_range(0, 3) == 0) ? 7 : 1;
    n_left = $countones(pick);
    first = 1'b1;
    for (int i = 0; i < 8; i++) begin
      idx = (first_dir + i * dir_step) % 8;
      if (pick[idx]) begin
        n_left--;
        if (shaped) begin
          b.vx = CW'(cx * 16 + DIR_A[idx] * radius / 10);
          b.vy = CW'(cy * 16 + DIR_B[idx] * radius / 10);
          case (zstyle)
            0: b.vz = CW'(cz * 16);
            1: b.vz = CW'(cz * 16 + DIR_B[idx] * radius / 10);
            default: b.vz = CW'($urandom);
          endcase
        end else begin
          b.vx = CW'($urandom);
          b.vy = CW'($urandom);
          b.vz = CW'($urandom);
        end
        if (shaped && first) begin
          b.px = PTW'(qx);
          b.py = PTW'(qy);
          b.pz = PTW'(qz);
        end else begin
          b.px = PTW'($urandom);
          b.py = PTW'($urandom);
          b.pz = PTW'($urandom);
        end
        b.last = (n_left == 0);
        send_vertex(b, 1'b0, 1'b0);
        first = 1'b0;
      end
    end
  endtask

  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, receiver_max_stall);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin : result_check
    logic want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (expected_inside.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result beat: inside_res=%0b", result_ch.inside_res);
      end else begin
        want = expected_inside.pop_front();
        if (result_ch.inside_res !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Result beat %0d: expected inside_res=%0b, got %0b",
                     results_seen, want, result_ch.inside_res);
        end else if (want) begin
          inside_count++;
        end
      end
    end
  end

  initial begin
    int phase_start;
    vertex_ch.valid       <= 1'b0;
    vertex_ch.vertex_x    <= '0;
    vertex_ch.vertex_y    <= '0;
    vertex_ch.vertex_z    <= '0;
    vertex_ch.point_x     <= '0;
    vertex_ch.point_y     <= '0;
    vertex_ch.point_z     <= '0;
    vertex_ch.last_vertex <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].cfg_op == CFG_SET_XY) write_check_xz(MODE_XY);
      else if (DIRECTED_ROWS[i].cfg_op == CFG_SET_XZ) write_check_xz(MODE_XZ);
      send_vertex(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].typed_inside);
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_check_xz(ph[0] ? MODE_XY : MODE_XZ);
      sender_max_gap = ph[0] ? 0 : IDLE_MAX;
      receiver_max_stall = (ph == 0 || ph == 3) ? IDLE_MAX : 0;
      phase_start = vertices_sent;
      while (vertices_sent - phase_start < PHASE_VERTICES) send_random_polygon();
    end

    vertex_ch.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_inside.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_inside.size() != 0) begin
      $display("%0d expected results never arrived", expected_inside.size());
      fail_count += expected_inside.size();
    end

    $display("Sent %0d vertices over xy-only and xz settings (%0d register writes).",
             vertices_sent, cfg_writes);
    $display("Checked %0d inside flags, %0d of them set; %0d failures.",
             results_seen, inside_count, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", expected_inside.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
